### rtl/core/append_and_remove_all_table_unit_macros.svh
// assertion macros shared by the table unit rtl
`ifndef APPEND_AND_REMOVE_ALL_TABLE_UNIT_MACROS_SVH
`define APPEND_AND_REMOVE_ALL_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define ARAT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("table unit check failed: always");
// consequent holds in the cycle after the antecedent
`define ARAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("table unit check failed: next");
`else
`define ARAT_ASSERT_ALWAYS(lbl, cond)
`define ARAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/arat_pkg.sv
// shared types and constants of the table unit
package arat_pkg;

  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int CAP_W    = 9;
  localparam int CNT_OUT_W = 9;
  localparam int OUT_DATA_W = 24;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] fill_count;
    logic [CNT_OUT_W-1:0] removed_count;
    logic                 status;
  } result_t;

endpackage

### rtl/core/arat_ram.sv
// generic simple dual-port ram with registered read
module arat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/append_and_remove_all_table_unit.sv
// ordered table of 32-bit words with push, remove-all-matches and clear requests
//
// the table unit keeps up to min(capacity, DEPTH) signed words in request order in a
// single simple dual-port ram. each request on the in_ stream gives exactly one
// result on the out_ stream. a push appends at the position given by the fill count
// or is refused with status 1 when the table is at its limit; a remove walks every
// held entry through the ram, one read per entry and one write-back per survivor,
// keeping the survivors in order and reporting how many matched; a clear just zeroes
// the count. push, clear, the unused code and a remove of an empty table load the
// result register in the accepting cycle; a remove of a non-empty table steps through
// the accepting cycle, one read per entry, a trailing compare of the last entry and a
// closing step, paced by the single ram read port. one request is in flight at a
// time; a new request is taken as soon as the previous result has been taken (or is
// being taken). capacity may only be written while the unit is idle.
// no clearing pass is needed after reset: only positions below the fill count are
// ever read.
module append_and_remove_all_table_unit #(
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [arat_pkg::VALUE_W-1:0]         in_tdata,   // [31:0] item_value
  input  logic [arat_pkg::REQ_W-1:0]           in_tuser,   // [1:0] req_type
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [arat_pkg::OUT_DATA_W-1:0]      out_tdata,  // [0] status, [9:1] removed_count,
                                                           // [18:10] fill_count, [23:19] zero
  // capacity register
  input  logic                                 cfg_wr_en,
  input  logic [arat_pkg::CAP_W-1:0]           cfg_wr_data
);

  import arat_pkg::*;

  `include "append_and_remove_all_table_unit_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAP_W-1:0]    capacity_r;
  logic                out_valid_r, out_valid_nxt;
  // scan bookkeeping
  logic [CW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]       scan_len_r, scan_len_nxt;
  logic                rd_pending_r, rd_pending_nxt;
  // payload
  logic [VALUE_W-1:0]  key_r, key_nxt;
  result_t             result_r, result_nxt;

  // ram ports
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [VALUE_W-1:0]  ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [VALUE_W-1:0]  ram_rd_data;

  logic                req_accept;
  logic                table_full;

  // events watched by the checks
  logic                push_ok;
  logic                scan_done;

  // one request at a time, result register must be free by the next edge
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign req_accept = in_tvalid && in_tready;

  // refused when the count reaches capacity or the physical depth
  assign table_full = (LW'(count_r) >= LW'(capacity_r)) || (count_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    scan_len_nxt   = scan_len_r;
    rd_pending_nxt = 1'b0;
    key_nxt        = key_r;
    result_nxt     = result_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[AW-1:0];
    ram_wr_data    = in_tdata;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = rd_ptr_r[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (req_accept) begin
          result_nxt.status        = STATUS_DONE;
          result_nxt.removed_count = '0;
          case (in_tuser)
            REQ_PUSH: begin
              if (table_full) begin
                result_nxt.status = STATUS_FULL;
                result_nxt.fill_count = CNT_OUT_W'(count_r);
              end else begin
                ram_wr_en = 1'b1;
                count_nxt = count_r + 1'b1;
                result_nxt.fill_count = CNT_OUT_W'(count_r + 1'b1);
              end
              out_valid_nxt = 1'b1;
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                // nothing held, answer straight away
                result_nxt.fill_count = '0;
                out_valid_nxt = 1'b1;
              end else begin
                key_nxt      = in_tdata;
                rd_ptr_nxt   = '0;
                wr_ptr_nxt   = '0;
                scan_len_nxt = count_r;
                state_nxt    = ST_SCAN;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              result_nxt.fill_count = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              // unused code leaves the table untouched
              result_nxt.fill_count = CNT_OUT_W'(count_r);
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read side runs one entry ahead of the compare and write-back;
        // the write pointer never passes the read pointer, so the entry
        // being read is never the one being written
        if (rd_ptr_r != scan_len_r) begin
          ram_rd_en      = 1'b1;
          rd_ptr_nxt     = rd_ptr_r + 1'b1;
          rd_pending_nxt = 1'b1;
        end
        if (rd_pending_r) begin
          if (ram_rd_data != key_r) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_ptr_r[AW-1:0];
            ram_wr_data = ram_rd_data;
            wr_ptr_nxt  = wr_ptr_r + 1'b1;
          end
        end else if (rd_ptr_r == scan_len_r) begin
          // every entry compared and compacted
          count_nxt                = wr_ptr_r;
          result_nxt.status        = STATUS_DONE;
          result_nxt.removed_count = CNT_OUT_W'(scan_len_r - wr_ptr_r);
          result_nxt.fill_count    = CNT_OUT_W'(wr_ptr_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      scan_len_r   <= '0;
      rd_pending_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      scan_len_r   <= scan_len_nxt;
      rd_pending_r <= rd_pending_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    result_r <= result_nxt;
  end

  arat_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(result_r);

  // checks
  assign push_ok   = req_accept && (in_tuser == REQ_PUSH) && !table_full;
  assign scan_done = (state_r == ST_SCAN) && (state_nxt == ST_IDLE);

  `ARAT_ASSERT_ALWAYS(a_count_in_depth, count_r <= CW'(DEPTH))
  `ARAT_ASSERT_ALWAYS(a_compact_behind_read, (state_r != ST_SCAN) || (wr_ptr_r <= rd_ptr_r))
  `ARAT_ASSERT_ALWAYS(a_no_result_while_scanning, (state_r != ST_SCAN) || !out_valid_r)
  `ARAT_ASSERT_NEXT(a_push_grows, push_ok, count_r == $past(count_r) + 1'b1)
  `ARAT_ASSERT_NEXT(a_remove_never_grows, scan_done, count_r <= $past(scan_len_r))

endmodule

### tb/sv/append_and_remove_all_table_unit_test.sv
// self-checking stream testbench for the append and remove-all table unit
module append_and_remove_all_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arat_pkg::*;

  // geometry and run bounds
  localparam int TABLE_DEPTH = 256;
  // the limit sits far above the slowest legal run, so this only trips on a hang
  localparam int CYCLE_LIMIT = 3000000;
  // drain long enough for a remove of a full table to finish
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_REQUESTS = 95;

  // request code that the unit answers without touching the table
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // one row of the directed part: either a capacity write or a request
  typedef struct packed {
    logic                 is_cfg;
    logic [CAP_W-1:0]     cap;
    logic [REQ_W-1:0]     kind;
    logic [VALUE_W-1:0]   value;
    logic                 typed;
    logic                 want_status;
    logic [CNT_OUT_W-1:0] want_removed;
    logic [CNT_OUT_W-1:0] want_fill;
  } dir_row_t;

  localparam int DIRECTED_LEN = 25;

  // rows with typed = 1 carry a hand-written result, the rest use the predictor
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // empty table straight after reset
    '{1'b0, 9'd0,   REQ_REMOVE, 32'h0000_0000, 1'b1, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, STATUS_DONE, 9'd0, 9'd0},
    // extremes of the value field, one duplicated
    '{1'b0, 9'd0,   REQ_PUSH,   32'h8000_0000, 1'b1, STATUS_DONE, 9'd0, 9'd1},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h7FFF_FFFF, 1'b1, STATUS_DONE, 9'd0, 9'd2},
    '{1'b0, 9'd0,   REQ_PUSH,   32'hFFFF_FFFF, 1'b1, STATUS_DONE, 9'd0, 9'd3},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h8000_0000, 1'b1, STATUS_DONE, 9'd0, 9'd4},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0000, 1'b1, STATUS_DONE, 9'd0, 9'd5},
    // both copies of the most negative value go
    '{1'b0, 9'd0,   REQ_REMOVE, 32'h8000_0000, 1'b1, STATUS_DONE, 9'd2, 9'd3},
    '{1'b0, 9'd0,   REQ_UNUSED, 32'h1234_5678, 1'b1, STATUS_DONE, 9'd0, 9'd3},
    // capacity lowered below the fill count
    '{1'b1, 9'd2,   REQ_PUSH,   32'h0000_0000, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0001, 1'b1, STATUS_FULL, 9'd0, 9'd3},
    '{1'b0, 9'd0,   REQ_REMOVE, 32'h7FFF_FFFF, 1'b1, STATUS_DONE, 9'd1, 9'd2},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0005, 1'b1, STATUS_FULL, 9'd0, 9'd2},
    '{1'b0, 9'd0,   REQ_CLEAR,  32'hDEAD_BEEF, 1'b1, STATUS_DONE, 9'd0, 9'd0},
    // refill up to a small limit
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0005, 1'b1, STATUS_DONE, 9'd0, 9'd1},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0006, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0007, 1'b1, STATUS_FULL, 9'd0, 9'd2},
    // zero capacity refuses every push, removes still work
    '{1'b1, 9'd0,   REQ_PUSH,   32'h0000_0000, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h0000_0009, 1'b1, STATUS_FULL, 9'd0, 9'd2},
    '{1'b0, 9'd0,   REQ_REMOVE, 32'h0000_0005, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    // capacity above the depth is cut to the depth
    '{1'b1, 9'd511, REQ_PUSH,   32'h0000_0000, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_REMOVE, 32'hAAAA_5555, 1'b1, STATUS_DONE, 9'd0, 9'd1},
    '{1'b0, 9'd0,   REQ_PUSH,   32'h5555_AAAA, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    '{1'b0, 9'd0,   REQ_REMOVE, 32'h0000_0006, 1'b0, STATUS_DONE, 9'd0, 9'd0},
    // back to the reset capacity for the random part
    '{1'b1, 9'd256, REQ_PUSH,   32'h0000_0000, 1'b0, STATUS_DONE, 9'd0, 9'd0}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side, all known from time zero
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;

  // result side
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // capacity register port
  logic                  cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]      cfg_wr_data = '0;

  // hand-written result travelling alongside the request it belongs to
  logic                  typed_valid = 1'b0;
  result_t               typed_want = '0;

  // shadow copy of the unit's state, advanced at every accepted request
  logic [VALUE_W-1:0]    shadow_entries [TABLE_DEPTH];
  int unsigned           shadow_count = 0;
  logic [CAP_W-1:0]      shadow_capacity = CAP_RESET;

  // results still owed by the unit, oldest first
  result_t               pending_results [$];

  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;
  int                    burst_left = 0;
  logic [VALUE_W-1:0]    value_pool [8];

  append_and_remove_all_table_unit #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure in one of four modes drawn at random: no stalls at all,
  // coin-flip stalls, a fixed duty pattern and long random stalls
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 700 == 0) begin
      rx_mode <= $urandom_range(3, 0);
    end
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(1, 0) == 1);
      end
      2: begin
        out_tready <= (rx_tick % 8 != 0) && (rx_tick % 8 != 3);
      end
      default: begin
        out_tready <= ($urandom_range(5, 0) == 0);
      end
    endcase
  end

  // predicts one request against the shadow table and moves the shadow state on
  function automatic result_t apply_table_request(logic [REQ_W-1:0] kind,
                                                  logic [VALUE_W-1:0] value);
    result_t     res;
    int unsigned lim;
    int unsigned kept;
    res = '0;
    res.status = STATUS_DONE;
    // limit is the capacity, cut to the physical depth
    lim = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
    case (kind)
      REQ_PUSH: begin
        // also refused when a lowered capacity left the count above the limit
        if (shadow_count >= lim) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
        end
      end
      REQ_REMOVE: begin
        // compact survivors in order over every held entry
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] != value) begin
            shadow_entries[kept] = shadow_entries[i];
            kept++;
          end
        end
        res.removed_count = CNT_OUT_W'(shadow_count - kept);
        shadow_count = kept;
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    res.fill_count = CNT_OUT_W'(shadow_count);
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want_v, int unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               mismatch_count, cycle_count, what, want_v, got_v);
    end
  endtask

  // monitor: capacity writes and accepted requests feed the predictor, accepted
  // results are checked against the oldest prediction; everything is sampled at
  // the edge before any of this step's nonblocking updates land
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        shadow_capacity = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[18:0]);
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing owed, fill_count", 0, seen.fill_count);
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status) begin
            flag_mismatch("status", want.status, seen.status);
          end
          if (seen.removed_count !== want.removed_count) begin
            flag_mismatch("removed_count", want.removed_count, seen.removed_count);
          end
          if (seen.fill_count !== want.fill_count) begin
            flag_mismatch("fill_count", want.fill_count, seen.fill_count);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_table_request(in_tuser, in_tdata);
        // a typed-in row overrides the prediction, the shadow still moves on
        if (typed_valid) begin
          want = typed_want;
        end
        pending_results.push_back(want);
      end
    end
  end

  // sender: bursts of back-to-back requests separated by idle gaps of random length
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value,
                              input logic typed, input result_t want);
    int unsigned gap;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(40, 1);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= value;
    typed_valid <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // lets every owed result out before anything that needs the unit idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly values from a small pool so removes find matches, some fully random
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99, 0) < 85) begin
      return value_pool[$urandom_range(7, 0)];
    end
    return $urandom();
  endfunction

  initial begin
    result_t          want;
    logic [CAP_W-1:0] cap;
    logic [REQ_W-1:0] kind;
    int unsigned      pick;

    // pool keeps the value extremes, the rest is refreshed per phase
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) begin
      value_pool[i] = $urandom();
    end

    // synchronous reset held at the start, then released for good
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int r = 0; r < DIRECTED_LEN; r++) begin
      if (DIRECTED_ROWS[r].is_cfg) begin
        write_capacity(DIRECTED_ROWS[r].cap);
      end else begin
        want = '0;
        want.status = DIRECTED_ROWS[r].want_status;
        want.removed_count = DIRECTED_ROWS[r].want_removed;
        want.fill_count = DIRECTED_ROWS[r].want_fill;
        send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value,
                     DIRECTED_ROWS[r].typed, want);
      end
    end

    // fill the whole depth, overrun it by one, then scan the full table
    send_request(REQ_CLEAR, $urandom(), 1'b0, '0);
    repeat (TABLE_DEPTH + 1) begin
      send_request(REQ_PUSH, pick_value(), 1'b0, '0);
    end
    for (int i = 0; i < 8; i++) begin
      send_request(REQ_REMOVE, value_pool[i], 1'b0, '0);
    end

    // random phases, each under its own capacity; the count is carried over so a
    // lowered capacity often starts below the fill count
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 8)
        0: cap = 9'd1;
        1: cap = 9'd2;
        2: cap = CAP_W'($urandom_range(12, 3));
        3: cap = CAP_W'($urandom_range(64, 13));
        4: cap = 9'd0;
        5: cap = 9'd511;
        6: cap = CAP_W'($urandom_range(256, 1));
        default: cap = 9'd256;
      endcase
      write_capacity(cap);
      for (int i = 4; i < 8; i++) begin
        value_pool[i] = $urandom();
      end
      repeat (PHASE_REQUESTS) begin
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
          kind = REQ_PUSH;
        end else if (pick < 82) begin
          kind = REQ_REMOVE;
        end else if (pick < 92) begin
          kind = REQ_CLEAR;
        end else begin
          kind = REQ_UNUSED;
        end
        send_request(kind, pick_value(), 1'b0, '0);
      end
    end

    // drain, then give a full-table scan time to show up if one is still running
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
